// File: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Payload store geometry
  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  // Register reset values
  localparam logic [7:0] START_CODE_RST = 8'h80;
  localparam logic [7:0] END_CODE_RST   = 8'hFE;
  localparam logic [5:0] MAX_LEN_RST    = 6'd32;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_CODE = 2'd0;
  localparam logic [1:0] CFG_END_CODE   = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

  // Write request into the payload store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // Replay request from the parser to the replay sequencer
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } replay_req_t;

endpackage

// File: rtl/cfr_store.sv
// ----------------------------------------------------------------------------
// cfr_store
// Payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfr_store (
  input  logic                       clk,
  input  cfr_pkg::store_wr_t         wr,
  input  logic                       rd_en,
  input  logic [cfr_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem [cfr_pkg::MAX_PAYLOAD];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/cfr_parser.sv
// ----------------------------------------------------------------------------
// cfr_parser
// Frame parser: hunts start, checks length, stores payload, checks end code and sum.
// ----------------------------------------------------------------------------
module cfr_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input item
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  // Configuration writes
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  // Store write and replay request
  output cfr_pkg::store_wr_t     wr,
  output cfr_pkg::replay_req_t   req
);

  typedef enum logic [3:0] {
    ST_HUNT = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_DATA = 4'b0100,
    ST_SUM  = 4'b1000
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [cfr_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [cfr_pkg::LEN_W-1:0] taken_r, taken_nxt;
  logic [7:0]                start_code_r;
  logic [7:0]                end_code_r;
  logic [5:0]                max_len_r;
  logic [5:0]                limit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= cfr_pkg::START_CODE_RST;
      end_code_r   <= cfr_pkg::END_CODE_RST;
      max_len_r    <= cfr_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfr_pkg::CFG_START_CODE: start_code_r <= cfg_data;
        cfr_pkg::CFG_END_CODE:   end_code_r   <= cfg_data;
        cfr_pkg::CFG_MAX_LENGTH: max_len_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Length limit, capped at the store depth
  assign limit = (max_len_r > 6'(cfr_pkg::MAX_PAYLOAD)) ? 6'(cfr_pkg::MAX_PAYLOAD)
                                                        : max_len_r;

  // Frame state machine
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    taken_nxt = taken_r;
    wr.en     = 1'b0;
    wr.addr   = taken_r[cfr_pkg::ADDR_W-1:0];
    wr.data   = rx_byte;
    req.start = 1'b0;
    req.len   = len_r;
    if (accept) begin
      unique case (phase_r)
        ST_HUNT: begin
          if (rx_byte == start_code_r) begin
            phase_nxt = ST_LEN;
            sum_nxt   = rx_byte;
            len_nxt   = '0;
            taken_nxt = '0;
          end
        end
        ST_LEN: begin
          if (rx_byte != 8'd0 && rx_byte <= {2'b00, limit}) begin
            phase_nxt = ST_DATA;
            sum_nxt   = sum_r + rx_byte;
            len_nxt   = rx_byte[cfr_pkg::LEN_W-1:0];
            taken_nxt = '0;
          end else begin
            phase_nxt = ST_HUNT;
          end
        end
        ST_DATA: begin
          // accepted length never exceeds the store depth
          wr.en     = 1'b1;
          taken_nxt = taken_r + 1'b1;
          sum_nxt   = sum_r + rx_byte;
          if (taken_nxt == len_r) begin
            phase_nxt = (rx_byte == end_code_r) ? ST_SUM : ST_HUNT;
          end
        end
        ST_SUM: begin
          phase_nxt = ST_HUNT;
          req.start = (sum_r == rx_byte);
        end
        default: phase_nxt = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_HUNT;
      sum_r   <= '0;
      len_r   <= '0;
      taken_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

// File: rtl/cfr_replay.sv
// ----------------------------------------------------------------------------
// cfr_replay
// Replay sequencer: reads the stored payload and drives the result register.
// ----------------------------------------------------------------------------
module cfr_replay (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfr_pkg::replay_req_t       req,
  // Store read port
  output logic                       rd_en,
  output logic [cfr_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_payload_byte,
  output logic [4:0]                 out_byte_index,
  output logic                       out_is_last,
  // High while a replay is in flight
  output logic                       busy
);

  logic                       active_r;
  logic [cfr_pkg::LEN_W-1:0]  cnt_r;
  logic [cfr_pkg::LEN_W-1:0]  len_r;
  logic                       pend_r;
  logic [cfr_pkg::ADDR_W-1:0] pend_idx_r;
  logic                       pend_last_r;
  logic                       oval_r;
  logic [7:0]                 obyte_r;
  logic [4:0]                 oidx_r;
  logic                       olast_r;
  logic                       slot_free;
  logic [cfr_pkg::LEN_W-1:0]  cnt_inc;

  // Issue a read only when the result register is free by the time data lands
  assign slot_free = !oval_r || !out_stall;
  assign cnt_inc   = cnt_r + 1'b1;
  assign rd_en     = active_r && !pend_r && slot_free;
  assign rd_addr   = cnt_r[cfr_pkg::ADDR_W-1:0];
  assign busy      = active_r || pend_r || oval_r;

  // Read sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      pend_r <= rd_en;
      if (req.start) begin
        active_r <= 1'b1;
      end else if (rd_en && cnt_inc == len_r) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      len_r <= req.len;
    end else if (rd_en) begin
      cnt_r <= cnt_inc;
    end
    if (rd_en) begin
      pend_idx_r  <= cnt_r[cfr_pkg::ADDR_W-1:0];
      pend_last_r <= (cnt_inc == len_r);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (pend_r) begin
      oval_r <= 1'b1;
    end else if (!out_stall) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      obyte_r <= rd_data;
      oidx_r  <= 5'(pend_idx_r);
      olast_r <= pend_last_r;
    end
  end

  assign out_valid        = oval_r;
  assign out_payload_byte = obyte_r;
  assign out_byte_index   = oidx_r;
  assign out_is_last      = olast_r;

endmodule

// File: rtl/checksummed_frame_receiver.sv
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Length-prefixed frame receiver with an 8-bit sum check and payload replay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one link byte per
//   item. A frame is start code, length (1..max_length, at most 32), payload
//   whose last byte is the end code, then the 8-bit sum of all prior bytes.
//   Payload bytes go into a 32-entry store with a registered read.
//   Result channel (out_valid / out_stall / out_*) carries the payload of a
//   good frame, one byte per item, with its index and a last flag.
//   Throughput: one input item per cycle while parsing. After a good checksum
//   byte the replay reads each stored byte and loads it into the result
//   register; no new store read is issued while a read is still pending.
//   in_stall is high while a replay is in flight, so the store is never read
//   and written in the same frame window; a stalled result holds and pauses
//   the replay.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; index 0 start code, 1 end code, 2 max length, others
//   ignored. Reset restores the register defaults and returns to hunting.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic [4:0] out_byte_index,
  output logic       out_is_last,
  // Configuration port
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfr_pkg::store_wr_t         wr;
  cfr_pkg::replay_req_t       req;
  logic                       rd_en;
  logic [cfr_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 rd_data;
  logic                       busy;
  logic                       accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  // Parser and configuration registers
  cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .req       (req)
  );

  // Payload store
  cfr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Replay of a good frame
  cfr_replay u_replay (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_is_last      (out_is_last),
    .busy             (busy)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checksummed frame receiver. Byte streams made of
// good frames, dropped frames, rejected lengths and line noise are driven with
// random idle and stall gaps. A parser model in the scoreboard predicts each
// replayed payload byte, and every result is compared field by field.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_BODY, PH_CHECK} rx_phase_t;

typedef struct {
  logic [7:0] data;
  logic [4:0] index;
  logic       last;
} payload_item_t;

typedef logic [7:0] byte_stream_t [$];

// Frame parser model plus the queue of payload bytes still to be replayed
class frame_scoreboard;
  logic [7:0]    start_code;
  logic [7:0]    end_code;
  logic [5:0]    max_length;
  rx_phase_t     phase;
  logic [7:0]    running_sum;
  logic [5:0]    frame_len;
  logic [5:0]    taken;
  logic [7:0]    store [cfr_pkg::MAX_PAYLOAD];
  payload_item_t expected_payload [$];
  int            errors;

  function new();
    start_code  = cfr_pkg::START_CODE_RST;
    end_code    = cfr_pkg::END_CODE_RST;
    max_length  = cfr_pkg::MAX_LEN_RST;
    phase       = PH_HUNT;
    running_sum = 8'h00;
    frame_len   = 6'd0;
    taken       = 6'd0;
    errors      = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] value);
    case (idx)
      cfr_pkg::CFG_START_CODE: start_code = value;
      cfr_pkg::CFG_END_CODE:   end_code   = value;
      cfr_pkg::CFG_MAX_LENGTH: max_length = value[5:0];
      default: ;
    endcase
  endfunction

  // Advance the parser by one link byte; a good checksum queues the replay
  function void note_rx_byte(logic [7:0] d);
    int            lim;
    payload_item_t item;
    lim = (max_length > cfr_pkg::MAX_PAYLOAD) ? cfr_pkg::MAX_PAYLOAD : max_length;
    case (phase)
      PH_HUNT: begin
        if (d == start_code) begin
          phase       = PH_LENGTH;
          running_sum = d;
          frame_len   = 6'd0;
          taken       = 6'd0;
        end
      end
      PH_LENGTH: begin
        if (d >= 1 && d <= lim) begin
          phase       = PH_BODY;
          running_sum = running_sum + d;
          frame_len   = d[5:0];
          taken       = 6'd0;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        store[taken[4:0]] = d;
        taken       = taken + 6'd1;
        running_sum = running_sum + d;
        if (taken == frame_len) begin
          phase = (d == end_code) ? PH_CHECK : PH_HUNT;
        end
      end
      default: begin
        phase = PH_HUNT;
        if (running_sum == d) begin
          for (int k = 0; k < frame_len; k++) begin
            item.data  = store[k];
            item.index = k[4:0];
            item.last  = (k + 1 == frame_len);
            expected_payload.push_back(item);
          end
        end
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task check_payload(logic [7:0] data, logic [4:0] index, logic last);
    payload_item_t want;
    if (expected_payload.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h index=%0d last=%0b",
                                data, index, last));
    end else begin
      want = expected_payload.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("payload_byte %02h, expected %02h (index %0d)",
                                  data, want.data, want.index));
      if (index !== want.index)
        report_mismatch($sformatf("byte_index %0d, expected %0d", index, want.index));
      if (last !== want.last)
        report_mismatch($sformatf("is_last %0b, expected %0b (index %0d)",
                                  last, want.last, want.index));
    end
  endtask

  function int pending();
    return expected_payload.size();
  endfunction
endclass

module tb_top;

  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int SETTLE_CYCLES       = 8;
  localparam int DRAIN_CYCLES        = 24;
  localparam int STALL_LIMIT         = 3000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic [4:0] out_byte_index;
  logic       out_is_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  frame_scoreboard sb = new();
  int  bytes_sent;
  bit  sender_fast;
  int  idle_cycles;

  checksummed_frame_receiver u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_is_last      (out_is_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitors: register writes, accepted link bytes, accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_rx_byte(in_rx_byte);
      if (out_valid && !out_stall)
        sb.check_payload(out_payload_byte, out_byte_index, out_is_last);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item accepted for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side back-pressure, with runs of no stall at all
  initial begin : result_stall
    int hold;
    int run_left;
    bit fast;
    bit acc;
    out_stall = 1'b0;
    run_left  = 0;
    fast      = 1'b0;
    forever begin
      if (run_left == 0) begin
        fast     = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      hold = fast ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        acc = out_valid;
        @(posedge clk);
      end while (!acc);
    end
  end

  // One link byte, after a random idle gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit acc;
    gap = sender_fast ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    bytes_sent++;
  endtask

  task automatic send_stream(input byte_stream_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the link idle until every queued result is out, then settle
  task automatic pause_until_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Frame under the current settings: start, length, payload, sum
  function automatic byte_stream_t make_frame(int len, bit bad_end, bit bad_sum);
    byte_stream_t q;
    logic [7:0]   sum;
    logic [7:0]   b;
    q.push_back(sb.start_code);
    q.push_back(8'(len));
    sum = sb.start_code + 8'(len);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1)
        b = bad_end ? (sb.end_code ^ 8'($urandom_range(1, 255))) : sb.end_code;
      else
        b = 8'($urandom_range(0, 255));
      q.push_back(b);
      sum = sum + b;
    end
    q.push_back(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    return q;
  endfunction

  // Mostly good frames of small size; some dropped, rejected or noise
  task automatic send_random_frame(input bit full_length);
    byte_stream_t q;
    int lim;
    int len;
    int kind;
    int r;
    lim  = (sb.max_length > cfr_pkg::MAX_PAYLOAD) ? cfr_pkg::MAX_PAYLOAD : sb.max_length;
    kind = full_length ? 0 : $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    if (full_length)   len = lim;
    else if (lim == 0) len = $urandom_range(1, 4);
    else if (r < 70)   len = $urandom_range(1, (lim < 4) ? lim : 4);
    else if (r < 90)   len = $urandom_range(1, lim);
    else               len = lim;
    if (kind < 81) begin
      q = make_frame(len, (kind >= 65 && kind < 73), (kind >= 73));
    end else if (kind < 87) begin
      q.push_back(sb.start_code);
      q.push_back(8'h00);
    end else if (kind < 93) begin
      q.push_back(sb.start_code);
      q.push_back(8'($urandom_range(lim + 1, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
    end
    send_stream(q);
  endtask

  // Random max_length value, upper data bits random too
  function automatic logic [7:0] pick_max_length();
    logic [5:0] len;
    case ($urandom_range(0, 3))
      0:       len = 6'($urandom_range(1, 6));
      1:       len = 6'($urandom_range(1, 63));
      2:       len = 6'd32;
      default: len = 6'($urandom_range(7, 16));
    endcase
    return {2'($urandom_range(0, 3)), len};
  endfunction

  // Register settings per test phase; the first three hit the extremes
  task automatic configure_phase(input int p);
    case (p)
      0: begin
        write_reg(cfr_pkg::CFG_START_CODE, 8'h00);
        write_reg(cfr_pkg::CFG_END_CODE, 8'hFF);
        write_reg(cfr_pkg::CFG_MAX_LENGTH, 8'h01);
      end
      1: begin
        write_reg(cfr_pkg::CFG_START_CODE, 8'hFF);
        write_reg(cfr_pkg::CFG_END_CODE, 8'h00);
        write_reg(cfr_pkg::CFG_MAX_LENGTH, 8'hFF);   // 63, capped to the store size
      end
      2: begin
        write_reg(cfr_pkg::CFG_MAX_LENGTH, 8'hC0);   // zero: every frame rejected
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
      end
      default: begin
        if ($urandom_range(0, 1))
          write_reg(cfr_pkg::CFG_START_CODE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1))
          write_reg(cfr_pkg::CFG_END_CODE, 8'($urandom_range(0, 255)));
        write_reg(cfr_pkg::CFG_MAX_LENGTH, pick_max_length());
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Main sequence
  initial begin : stimulus
    logic [7:0] fixed_bytes [16];
    int target;
    // start byte inside a body, wrong terminator, then a good frame carrying one
    fixed_bytes = '{
      cfr_pkg::START_CODE_RST, 8'h00,                    // zero length
      cfr_pkg::START_CODE_RST, 8'd33,                    // over the limit
      8'hFF, 8'h00,                                      // noise while hunting
      cfr_pkg::START_CODE_RST, 8'h02, cfr_pkg::START_CODE_RST, 8'h11, 8'h13,
      cfr_pkg::START_CODE_RST, 8'h02, cfr_pkg::START_CODE_RST,
      cfr_pkg::END_CODE_RST, 8'h00
    };
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    cfg_valid   = 1'b0;
    cfg_index   = cfr_pkg::CFG_START_CODE;
    cfg_data    = 8'h00;
    idle_cycles = 0;
    bytes_sent  = 0;
    sender_fast = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings
    send_stream(make_frame(1, 1'b0, 1'b0));
    foreach (fixed_bytes[i]) send_byte(fixed_bytes[i]);
    send_stream(make_frame(3, 1'b0, 1'b1));

    // Random phases, each under its own register settings
    for (int p = 0; p < 8; p++) begin
      pause_until_drained(SETTLE_CYCLES);
      configure_phase(p);
      sender_fast = (p % 3 == 1);
      target = bytes_sent + ((p == 2) ? 10 : 30);
      if (p == 1) send_random_frame(1'b1);
      while (bytes_sent < target) send_random_frame(1'b0);
    end

    pause_until_drained(DRAIN_CYCLES);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cfr_pkg.sv
rtl/cfr_store.sv
rtl/cfr_parser.sv
rtl/cfr_replay.sv
rtl/checksummed_frame_receiver.sv
tb/sv/tb_top.sv
